/* hdl/line_command_keyword_decoder_defines.svh */
// Assertion macros shared by the line command keyword decoder modules.
// Needs clk_i and rst_ni in the scope of the module that uses them.
`ifndef LINE_COMMAND_KEYWORD_DECODER_DEFINES_SVH
`define LINE_COMMAND_KEYWORD_DECODER_DEFINES_SVH

// Expression holds at every clock edge out of reset.
`define LCKD_ASSERT_HOLDS(label, expr) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) \
    else $error("lckd assertion failed");

// Consequent holds in the same cycle as the antecedent.
`define LCKD_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("lckd assertion failed");

// Consequent holds in the cycle after the antecedent.
`define LCKD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("lckd assertion failed");

`endif

/* hdl/lckd_pkg.sv */
// Types and constants of the line command keyword decoder.
// No dependencies; imported by every module of the block but lckd_fifo.
package lckd_pkg;

  // Character classes produced by the front classifier
  typedef enum logic [3:0] {
    SYM_OTHER,
    SYM_ZERO,
    SYM_TERM,
    SYM_A,
    SYM_B,
    SYM_D,
    SYM_E,
    SYM_L,
    SYM_O,
    SYM_P,
    SYM_R,
    SYM_S,
    SYM_T,
    SYM_U
  } sym_e;

  typedef enum logic [2:0] {
    ACT_NONE       = 3'd0,
    ACT_BOOTLOADER = 3'd1,
    ACT_APP        = 3'd2,
    ACT_RESET      = 3'd3,
    ACT_STATUS     = 3'd4,
    ACT_UNKNOWN    = 3'd5
  } action_e;

  localparam logic [7:0] CHAR_CR  = 8'h0D;
  localparam logic [7:0] CHAR_LF  = 8'h0A;
  localparam logic [7:0] CHAR_NUL = 8'h00;

  localparam int KW_COUNT = 4;
  localparam int KW_MAX   = 10;
  localparam int KW_POS_W = 4;

  // Keyword spelling as symbol codes, padded past the keyword length
  localparam sym_e KW_SYM [KW_COUNT][KW_MAX] = '{
    '{SYM_B, SYM_O, SYM_O, SYM_T, SYM_L, SYM_O, SYM_A, SYM_D, SYM_E, SYM_R},
    '{SYM_A, SYM_P, SYM_P, SYM_OTHER, SYM_OTHER, SYM_OTHER, SYM_OTHER,
      SYM_OTHER, SYM_OTHER, SYM_OTHER},
    '{SYM_R, SYM_E, SYM_S, SYM_E, SYM_T, SYM_OTHER, SYM_OTHER, SYM_OTHER,
      SYM_OTHER, SYM_OTHER},
    '{SYM_S, SYM_T, SYM_A, SYM_T, SYM_U, SYM_S, SYM_OTHER, SYM_OTHER,
      SYM_OTHER, SYM_OTHER}
  };

  localparam logic [KW_POS_W-1:0] KW_LEN [KW_COUNT] = '{4'd10, 4'd3, 4'd5, 4'd6};

  localparam action_e KW_ACT [KW_COUNT] = '{
    ACT_BOOTLOADER, ACT_APP, ACT_RESET, ACT_STATUS
  };

  // Word between front and back
  typedef struct packed {
    sym_e sym;
  } cmd_t;

  // Word between back and result queue
  typedef struct packed {
    action_e action;
    logic    overflow;
  } res_t;

  localparam int CMD_W = $bits(cmd_t);
  localparam int RES_W = $bits(res_t);

endpackage

/* hdl/line_command_keyword_decoder.sv */
// Top level of the line command keyword decoder.
// Depends on lckd_pkg, lckd_front, lckd_back and lckd_fifo.

// Collects control-channel bytes into a line of up to LINE_CAPACITY-1
// characters and, on CR or LF, reports whether the line reads BOOTLOADER,
// APP, RESET or STATUS (action 1..4), or is an unknown command (5). The
// line compares up to its first zero byte. An empty line gives action 0.
// Every accepted byte yields exactly one result word; a byte that would
// overfill the line clears it, is dropped, and flags overflow. Both sides
// behave as queues: push/full in, empty/pop out. One byte per clock is
// sustained while the result queue is popped; each byte goes from the front
// queue through the back stage, which writes its word into the result
// queue. The back stage updates the line length and a match flag per
// keyword each time it takes a byte. The characters themselves are not
// stored: the match flags carry all that the comparison needs.
module line_command_keyword_decoder #(
  parameter int LINE_CAPACITY = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [7:0] data_byte_i,
  output logic       empty,
  input  logic       pop,
  output logic [2:0] action_o,
  output logic       overflow_o
);
  import lckd_pkg::*;

  cmd_t             cmd;
  logic             cmd_empty;
  logic             cmd_pop;
  res_t             res_in;
  logic             res_push;
  logic             res_full;
  logic [RES_W-1:0] res_raw;
  res_t             res_out;

  // Front: classify byte, queue it
  lckd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .data_byte_i (data_byte_i),
    .full_o      (full),
    .cmd_pop_i   (cmd_pop),
    .cmd_o       (cmd),
    .cmd_empty_o (cmd_empty)
  );

  // Back: line tracking and keyword decision
  lckd_back #(
    .LINE_CAPACITY (LINE_CAPACITY)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .cmd_empty_i (cmd_empty),
    .cmd_pop_o   (cmd_pop),
    .res_o       (res_in),
    .res_push_o  (res_push),
    .res_full_i  (res_full)
  );

  // Result queue decouples the back from the consumer
  lckd_fifo #(
    .WIDTH (RES_W),
    .DEPTH (2)
  ) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .wdata_i (res_in),
    .full_o  (res_full),
    .pop_i   (pop),
    .rdata_o (res_raw),
    .empty_o (empty)
  );

  assign res_out    = res_t'(res_raw);
  assign action_o   = res_out.action;
  assign overflow_o = res_out.overflow;

endmodule

/* hdl/lckd_fifo.sv */
// Small register queue used between the decoder stages.
// No package dependency; DEPTH must be a power of two, at least 2.
module lckd_fifo #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wptr_q, wptr_d;
  logic [PTR_W-1:0] rptr_q, rptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q + PTR_W'(do_push);
    rptr_d = rptr_q + PTR_W'(do_pop);
    cnt_d  = cnt_q + CNT_W'(do_push) - CNT_W'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule

/* hdl/lckd_front.sv */
// Front of the decoder: classifies each received byte and queues it.
// Depends on lckd_pkg and lckd_fifo.
module lckd_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  logic [7:0]         data_byte_i,
  output logic               full_o,
  input  logic               cmd_pop_i,
  output lckd_pkg::cmd_t     cmd_o,
  output logic               cmd_empty_o
);
  import lckd_pkg::*;

  cmd_t             cls;
  logic [CMD_W-1:0] cmd_raw;

  always_comb begin
    case (data_byte_i)
      CHAR_CR, CHAR_LF: cls.sym = SYM_TERM;
      CHAR_NUL:         cls.sym = SYM_ZERO;
      "A":              cls.sym = SYM_A;
      "B":              cls.sym = SYM_B;
      "D":              cls.sym = SYM_D;
      "E":              cls.sym = SYM_E;
      "L":              cls.sym = SYM_L;
      "O":              cls.sym = SYM_O;
      "P":              cls.sym = SYM_P;
      "R":              cls.sym = SYM_R;
      "S":              cls.sym = SYM_S;
      "T":              cls.sym = SYM_T;
      "U":              cls.sym = SYM_U;
      default:          cls.sym = SYM_OTHER;
    endcase
  end

  lckd_fifo #(
    .WIDTH (CMD_W),
    .DEPTH (2)
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push_i),
    .wdata_i (cls),
    .full_o  (full_o),
    .pop_i   (cmd_pop_i),
    .rdata_o (cmd_raw),
    .empty_o (cmd_empty_o)
  );

  assign cmd_o = cmd_t'(cmd_raw);

endmodule

/* hdl/lckd_back.sv */
// Back of the decoder: tracks line length and per-keyword match state,
// and produces one result word per byte. Depends on lckd_pkg.
`include "line_command_keyword_decoder_defines.svh"

module lckd_back #(
  parameter int LINE_CAPACITY = 32
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  lckd_pkg::cmd_t cmd_i,
  input  logic           cmd_empty_i,
  output logic           cmd_pop_o,
  output lckd_pkg::res_t res_o,
  output logic           res_push_o,
  input  logic           res_full_i
);
  import lckd_pkg::*;

  localparam int DEPTH = LINE_CAPACITY - 1;
  localparam int LEN_W = $clog2(LINE_CAPACITY);

  logic [LEN_W-1:0]    len_q, len_d;
  // ok_q[k]: stored prefix agrees with keyword k, and the byte just past
  // the keyword (if stored) is a zero that ends the line
  logic [KW_COUNT-1:0] ok_q, ok_d;
  logic [KW_COUNT-1:0] hit;
  logic                fire;

  assign fire       = !cmd_empty_i && !res_full_i;
  assign cmd_pop_o  = fire;
  assign res_push_o = fire;

  always_comb begin
    for (int k = 0; k < KW_COUNT; k++) begin
      hit[k] = ok_q[k] && (len_q >= LEN_W'(KW_LEN[k]));
    end
  end

  always_comb begin
    len_d        = len_q;
    ok_d         = ok_q;
    res_o.action = ACT_NONE;
    res_o.overflow = 1'b0;
    if (cmd_i.sym == SYM_TERM) begin
      if (len_q != '0) begin
        res_o.action = ACT_UNKNOWN;
        for (int k = KW_COUNT - 1; k >= 0; k--) begin
          if (hit[k]) res_o.action = KW_ACT[k];
        end
        len_d = '0;
        ok_d  = '1;
      end
    end else if (len_q < LEN_W'(DEPTH)) begin
      for (int k = 0; k < KW_COUNT; k++) begin
        if (len_q < LEN_W'(KW_LEN[k])) begin
          ok_d[k] = ok_q[k] && (cmd_i.sym == KW_SYM[k][len_q[KW_POS_W-1:0]]);
        end else if (len_q == LEN_W'(KW_LEN[k])) begin
          ok_d[k] = ok_q[k] && (cmd_i.sym == SYM_ZERO);
        end
      end
      len_d = len_q + LEN_W'(1);
    end else begin
      len_d          = '0;
      ok_d           = '1;
      res_o.overflow = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= '0;
      ok_q  <= '1;
    end else if (fire) begin
      len_q <= len_d;
      ok_q  <= ok_d;
    end
  end

  // Line never grows past the store depth
  `LCKD_ASSERT_HOLDS(a_len_bound, len_q <= LEN_W'(DEPTH))
  // An overflow result always restarts the line
  `LCKD_ASSERT_NEXT(a_ovf_clears, fire && res_o.overflow, len_q == '0 && ok_q == '1)
  // A decoded action only comes from a terminator
  `LCKD_ASSERT_SAME(a_act_on_term, fire && res_o.action != ACT_NONE,
                    cmd_i.sym == SYM_TERM && !res_o.overflow)
  // At most one keyword can match a given line
  `LCKD_ASSERT_SAME(a_one_hit, fire && cmd_i.sym == SYM_TERM, $onehot0(hit))

endmodule

/* test/tb_line_command_keyword_decoder.sv */
// Self-checking testbench for line_command_keyword_decoder.
// Feeds lines of bytes, predicts each result word in a scoreboard class.
// Depends on lckd_pkg and the RTL of the block only.
`timescale 1ns / 100ps

module tb_line_command_keyword_decoder;
  import lckd_pkg::*;

  localparam int LINE_CAP     = 32;
  localparam int STORE_DEPTH  = LINE_CAP - 1;
  localparam int RANDOM_ITEMS = 1750;
  localparam int BURST_ITEMS  = 150;   // bytes pushed while the reader holds off
  localparam int HOLD_CYCLES  = 300;   // long reader hold-off, fills the block
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int MAX_REPORTS  = 10;

  // Expected result word
  typedef struct {
    action_e action;
    logic    overflow;
  } result_word_t;

  // Tracks the line the block is collecting and queues the word each
  // accepted byte must produce.
  class line_decode_scoreboard #(int DEPTH = 31);
    logic [7:0]   line_chars[DEPTH];
    int           line_len;
    result_word_t expected_words[$];
    int           mismatches;

    function new();
      line_len   = 0;
      mismatches = 0;
    endfunction

    // Keyword lookup; the line ends at its first zero byte.
    function action_e match_keyword();
      string text;
      int    i;
      text = "";
      i    = 0;
      while (i < line_len && line_chars[i] != CHAR_NUL) begin
        text = {text, string'(line_chars[i])};
        i++;
      end
      case (text)
        "BOOTLOADER": return ACT_BOOTLOADER;
        "APP":        return ACT_APP;
        "RESET":      return ACT_RESET;
        "STATUS":     return ACT_STATUS;
        default:      return ACT_UNKNOWN;
      endcase
    endfunction

    function void note_byte(logic [7:0] b);
      result_word_t w;
      w.action   = ACT_NONE;
      w.overflow = 1'b0;
      if (b == CHAR_CR || b == CHAR_LF) begin
        if (line_len != 0) begin
          w.action = match_keyword();
          line_len = 0;
        end
      end else if (line_len < DEPTH) begin
        line_chars[line_len] = b;
        line_len++;
      end else begin
        // line full: drop byte, clear line
        line_len   = 0;
        w.overflow = 1'b1;
      end
      expected_words.push_back(w);
    endfunction

    function void check_word(logic [2:0] act, logic ovf);
      result_word_t w;
      if (expected_words.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected word: action %0d overflow %0d", act, ovf);
      end else begin
        w = expected_words.pop_front();
        if (act !== w.action || ovf !== w.overflow) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("mismatch: expected action %0d overflow %0d, got action %0d overflow %0d",
                     w.action, w.overflow, act, ovf);
        end
      end
    endfunction

    function int pending();
      return expected_words.size();
    endfunction

    function bit clean();
      if (expected_words.size() != 0)
        $display("%0d expected words never arrived", expected_words.size());
      return mismatches == 0 && expected_words.size() == 0;
    endfunction
  endclass

  logic       clk_i     = 1'b0;
  logic       rst_ni    = 1'b0;
  logic       push      = 1'b0;
  logic [7:0] data_byte = 8'h00;
  logic       pop       = 1'b0;
  logic       full;
  logic       empty;
  logic [2:0] action;
  logic       overflow;

  line_decode_scoreboard #(STORE_DEPTH) sb;

  // Shared between the byte sender and the word reader
  bit steady   = 1'b0;  // both sides run without idle cycles
  bit hold_req = 1'b0;  // asks the reader for one long hold-off
  int items_sent = 0;

  always #5 clk_i = ~clk_i;

  line_command_keyword_decoder #(
    .LINE_CAPACITY(LINE_CAP)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .data_byte_i (data_byte),
    .empty       (empty),
    .pop         (pop),
    .action_o    (action),
    .overflow_o  (overflow)
  );

  // Idle length: mostly none, some short, a few long.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(30, 80);
  endfunction

  // Any byte except a line terminator
  function automatic logic [7:0] body_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == CHAR_CR || b == CHAR_LF);
    return b;
  endfunction

  function automatic logic [7:0] pick_term();
    return $urandom_range(0, 1) ? CHAR_CR : CHAR_LF;
  endfunction

  function automatic string pick_keyword();
    case ($urandom_range(0, 3))
      0:       return "BOOTLOADER";
      1:       return "APP";
      2:       return "RESET";
      default: return "STATUS";
    endcase
  endfunction

  // Push one byte: optional idle first, then hold push until full drops.
  // Called right after a rising edge; returns right after the accepting edge.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = steady ? 0 : idle_len();
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push      <= 1'b1;
    data_byte <= b;
    do @(posedge clk_i); while (full);
    sb.note_byte(b);
    items_sent++;
  endtask

  task automatic send_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  // Sender stops and waits for every outstanding word. Always waits for
  // an edge so push never gets two assignments in one step.
  task automatic drain_results();
    push <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
  endtask

  // One random line. Mostly keywords, exact or slightly damaged, so the
  // compare logic is exercised deeply; the rest is letter soup, long lines
  // around the capacity, stray single bytes and empty lines.
  task automatic send_random_line();
    logic [7:0] body[$];
    string      kw;
    string      letters;
    int         kind;
    int         pos;
    int         n;
    int         i;
    bit         terminate;
    letters   = "ABDELOPRSTU";
    terminate = 1'b1;
    kind      = $urandom_range(0, 99);
    kw        = pick_keyword();
    for (i = 0; i < kw.len(); i++) body.push_back(kw[i]);
    pos = $urandom_range(0, body.size() - 1);
    if (kind < 40) begin
      // exact keyword
    end else if (kind < 50) begin
      body[pos] = body_byte();
    end else if (kind < 55) begin
      void'(body.pop_back());
    end else if (kind < 60) begin
      body.push_back(body_byte());
    end else if (kind < 65) begin
      // zero after the keyword: junk behind it is ignored
      body.push_back(CHAR_NUL);
      n = $urandom_range(0, 3);
      for (i = 0; i < n; i++) body.push_back(body_byte());
    end else if (kind < 68) begin
      body.push_front(CHAR_NUL);
    end else if (kind < 72) begin
      body[pos] = body[pos] ^ 8'h20;  // flip case
    end else if (kind < 82) begin
      body.delete();
      n = $urandom_range(1, 12);
      for (i = 0; i < n; i++)
        body.push_back($urandom_range(0, 1) ? letters[$urandom_range(0, 10)] : body_byte());
    end else if (kind < 90) begin
      // around the capacity: fits, exactly full, or overflows
      body.delete();
      n = $urandom_range(STORE_DEPTH - 2, STORE_DEPTH + 9);
      for (i = 0; i < n; i++) body.push_back(body_byte());
    end else if (kind < 96) begin
      // stray byte, may itself be a terminator
      body.delete();
      body.push_back(8'($urandom_range(0, 255)));
      terminate = 1'b0;
    end else begin
      body.delete();  // empty line
    end
    foreach (body[j]) send_byte(body[j]);
    if (terminate) send_byte(pick_term());
  endtask

  // Word reader: checks every accepted word, then picks pop for the next
  // cycle. The long hold-off is counted here, independent of the sender.
  initial begin
    int hold_left;
    int idle_left;
    hold_left = 0;
    idle_left = 0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (pop && !empty) sb.check_word(action, overflow);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else if (idle_left > 0) begin
        idle_left--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
        if (!steady) idle_left = idle_len();
      end
    end
  end

  // Cycle budget; a hung handshake ends the run here.
  initial begin
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("timeout after %0d cycles", cycles);
    $display("status: fail");
    $finish;
  end

  // Stimulus
  initial begin
    int start;
    int mark;
    bit burst_done;
    burst_done = 1'b0;
    sb = new();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: APP, RESET and STATUS with both terminators, an empty line, a
    // line of only a zero byte, and a keyword followed by a zero and junk.
    send_text("APP");
    send_byte(CHAR_CR);
    send_byte(CHAR_LF);
    send_text("RESET");
    send_byte(CHAR_LF);
    send_text("STATUS");
    send_byte(CHAR_CR);
    send_byte(CHAR_NUL);
    send_byte(CHAR_CR);
    send_text("APP");
    send_byte(CHAR_NUL);
    send_byte(8'hFF);
    send_byte(CHAR_LF);

    // Sender pause until every word has come back
    drain_results();

    start = items_sent;
    while (items_sent - start < RANDOM_ITEMS) begin
      if (!burst_done && items_sent - start >= RANDOM_ITEMS / 2) begin
        // Reader holds off while bytes keep coming: block fills, full rises
        burst_done = 1'b1;
        steady     = 1'b1;
        hold_req   = 1'b1;
        mark       = items_sent;
        while (items_sent - mark < BURST_ITEMS) send_random_line();
        steady = 1'b0;
      end
      if ($urandom_range(0, 39) == 0) steady = !steady;
      send_random_line();
    end

    drain_results();
    // Room for any stray word after the last expected one
    repeat (20) @(posedge clk_i);
    if (sb.clean())
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
